@@ rtl/ffha_pkg.sv @@
// Package for the first-fit heap allocator: heap geometry, field widths,
// operation codes and the header word layout. No dependencies.
`default_nettype none

package ffha_pkg;

  localparam int UNIT_BYTES   = 12;
  localparam int NUM_REGIONS  = 8;
  localparam int REGION_UNITS = 1024;
  localparam int HEAP_UNITS   = NUM_REGIONS * REGION_UNITS;
  localparam int WALK_LIMIT   = HEAP_UNITS + 2;

  localparam int MEM_AW  = $clog2(HEAP_UNITS);
  localparam int LINK_W  = MEM_AW + 1;
  localparam int SIZE_W  = $clog2(REGION_UNITS);
  localparam int CNT_W   = $clog2(HEAP_UNITS + 1);
  localparam int STEP_W  = $clog2(WALK_LIMIT + 1);
  localparam int REG_W   = $clog2(NUM_REGIONS + 1);
  localparam int BYTES_W = 16;
  localparam int ADDR_W  = 13;
  localparam int FREE_W  = 14;
  localparam int NU_W    = BYTES_W;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [CNT_W-1:0] FREE_INIT = CNT_W'(NUM_REGIONS * (REGION_UNITS - 1));

  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [SIZE_W-1:0] size;
  } hdr_t;

endpackage

`default_nettype wire

@@ rtl/ffha_unit_conv.sv @@
// Byte count to heap units (header included): two-stage reciprocal multiply
// with one correction step. Depends on ffha_pkg.
`default_nettype none

module ffha_unit_conv import ffha_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [BYTES_W-1:0] size_bytes,
  output logic                   out_valid,
  output logic [NU_W-1:0]        units
);

  localparam int X_W = BYTES_W + 1;
  localparam int SH  = 20;
  localparam logic [SH-1:0] RECIP = SH'((1 << SH) / UNIT_BYTES);

  logic [X_W-1:0]    x;
  logic [X_W-1:0]    x_q;
  logic [X_W+SH-1:0] prod_q;
  logic              v1;
  logic [X_W-1:0]    q0;
  logic [X_W-1:0]    back;
  logic [X_W-1:0]    rem;
  logic [X_W-1:0]    quo;

  assign x    = {1'b0, size_bytes} + X_W'(UNIT_BYTES - 1);
  assign q0   = X_W'(prod_q >> SH);
  assign back = X_W'(q0 * X_W'(UNIT_BYTES));
  assign rem  = x_q - back;
  assign quo  = (rem >= X_W'(UNIT_BYTES)) ? q0 + X_W'(1) : q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
    x_q    <= x;
    prod_q <= (X_W+SH)'(x) * (X_W+SH)'(RECIP);
    units  <= NU_W'(quo) + NU_W'(1);
  end

endmodule

`default_nettype wire

@@ rtl/first_fit_heap_allocator.sv @@
// First-fit heap allocator top level: request sequencer, header memory and
// counters. Depends on ffha_pkg and ffha_unit_conv.
//
// After reset the block lays out NUM_REGIONS region headers, one per cycle, with busy
// high. A request is taken when start is high and busy is low; its result shows for one
// cycle with done high and cannot be held off. Every list node visited costs one read of
// the single-port header memory plus the check; an allocate adds unit conversion and two
// write-backs, a release a header check, a neighbor read and two write-backs. A zero-byte
// allocate or an out-of-range release is answered straight from idle.
`default_nettype none

module first_fit_heap_allocator import ffha_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               func,
  input  wire logic [BYTES_W-1:0] size_bytes,
  input  wire logic [ADDR_W-1:0]  block_addr,
  output logic                    done,
  output logic                    ok,
  output logic [ADDR_W-1:0]       user_addr,
  output logic [FREE_W-1:0]       free_units,
  output logic [FREE_W-1:0]       min_free_units
);

  localparam int SUM_W = LINK_W + 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_CONV, S_A_TEST, S_A_CHK,
    S_R_RD, S_R_CHK, S_R_TEST, S_R_WCHK, S_R_MRG, S_WR1, S_WR2
  } state_t;

  state_t state;

  hdr_t mem [HEAP_UNITS];
  hdr_t rdata;
  hdr_t mem_wdata;
  logic [MEM_AW-1:0] mem_addr;
  logic mem_we;
  logic mem_re;

  logic [LINK_W-1:0] sentinel_link;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  min_free_count;
  logic [REG_W-1:0]  ridx;

  logic [LINK_W-1:0] pa;
  logic [SIZE_W-1:0] pa_size;
  logic [LINK_W-1:0] ca;
  logic [LINK_W-1:0] blk;
  logic [SIZE_W-1:0] c_size;
  logic [NU_W-1:0]   nu;
  logic [STEP_W-1:0] steps;
  logic              w1_en;
  logic [MEM_AW-1:0] w1_addr;
  hdr_t              w1_data;
  logic [MEM_AW-1:0] w2_addr;
  hdr_t              w2_data;
  logic [ADDR_W-1:0] user_res;

  logic              conv_valid;
  logic [NU_W-1:0]   conv_units;
  logic [LINK_W-1:0] blk_in;
  logic [LINK_W-1:0] init_link;
  logic [NU_W:0]     cur_sz;
  logic [SIZE_W-1:0] carve_s;
  logic [LINK_W-1:0] carve_h;
  logic [CNT_W-1:0]  fc_whole;
  logic [CNT_W-1:0]  fc_carve;
  logic              found;
  logic              fwd_merge;
  logic              back_merge;
  hdr_t              c_new;

  ffha_unit_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy && func == FUNC_ALLOC && size_bytes != '0),
    .size_bytes(size_bytes),
    .out_valid (conv_valid),
    .units     (conv_units)
  );

  assign busy           = (state != S_IDLE);
  assign free_units     = FREE_W'(free_count);
  assign min_free_units = FREE_W'(min_free_count);

  assign blk_in    = LINK_W'(block_addr);
  assign init_link = (ridx + REG_W'(1) < REG_W'(NUM_REGIONS))
                   ? LINK_W'((ridx + REG_W'(1)) * REGION_UNITS + 1) : '0;
  assign cur_sz    = (NU_W+1)'(rdata.size);
  assign carve_s   = rdata.size - SIZE_W'(nu);
  assign carve_h   = ca + LINK_W'(carve_s);
  assign fc_whole  = free_count - CNT_W'(rdata.size);
  assign fc_carve  = free_count - CNT_W'(nu);

  assign found = (blk > pa && blk < ca) || (pa >= ca && (blk > pa || blk < ca));
  assign fwd_merge  = (ca != '0) && (SUM_W'(blk) + SUM_W'(c_size) == SUM_W'(ca));
  assign back_merge = (pa != '0) && (SUM_W'(pa) + SUM_W'(pa_size) == SUM_W'(blk));
  assign c_new = fwd_merge ? '{link: rdata.link, size: c_size + rdata.size}
                           : '{link: ca, size: c_size};

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = MEM_AW'(ca - LINK_W'(1));
    mem_wdata = w2_data;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = MEM_AW'(ridx * REGION_UNITS);
        mem_wdata = '{link: init_link, size: SIZE_W'(REGION_UNITS - 1)};
      end
      S_A_TEST, S_R_TEST: mem_re = 1'b1;
      S_R_RD: begin
        mem_re   = 1'b1;
        mem_addr = MEM_AW'(blk - LINK_W'(1));
      end
      S_WR1: begin
        mem_we    = w1_en;
        mem_addr  = w1_addr;
        mem_wdata = w1_data;
      end
      S_WR2: begin
        mem_we   = 1'b1;
        mem_addr = w2_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_INIT;
      ridx           <= '0;
      sentinel_link  <= LINK_W'(1);
      free_count     <= FREE_INIT;
      min_free_count <= FREE_INIT;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          ridx <= ridx + REG_W'(1);
          if (ridx == REG_W'(NUM_REGIONS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            blk <= blk_in;
            if (func == FUNC_ALLOC) begin
              if (size_bytes == '0) begin
                done      <= 1'b1;
                ok        <= 1'b0;
                user_addr <= '0;
              end else begin
                state <= S_A_CONV;
              end
            end else if (blk_in == '0 || blk_in > LINK_W'(HEAP_UNITS)) begin
              done      <= 1'b1;
              ok        <= 1'b0;
              user_addr <= '0;
            end else begin
              state <= S_R_RD;
            end
          end
        end
        S_A_CONV: begin
          if (conv_valid) begin
            nu      <= conv_units;
            pa      <= '0;
            pa_size <= SIZE_W'(1);
            ca      <= sentinel_link;
            steps   <= '0;
            state   <= S_A_TEST;
          end
        end
        S_A_TEST: begin
          if (ca == '0 || steps == STEP_W'(WALK_LIMIT)) begin
            done      <= 1'b1;
            ok        <= 1'b0;
            user_addr <= '0;
            state     <= S_IDLE;
          end else begin
            state <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (cur_sz >= (NU_W+1)'(nu)) begin
            state <= S_WR1;
            if (cur_sz <= (NU_W+1)'(nu) + (NU_W+1)'(1)) begin
              w1_en   <= (pa != '0);
              w1_addr <= MEM_AW'(pa - LINK_W'(1));
              w1_data <= '{link: rdata.link, size: pa_size};
              if (pa == '0) begin
                sentinel_link <= rdata.link;
              end
              w2_addr  <= MEM_AW'(ca - LINK_W'(1));
              w2_data  <= '{link: ca, size: rdata.size};
              user_res <= ADDR_W'(ca);
              free_count <= fc_whole;
              if (fc_whole < min_free_count) begin
                min_free_count <= fc_whole;
              end
            end else begin
              w1_en   <= 1'b1;
              w1_addr <= MEM_AW'(ca - LINK_W'(1));
              w1_data <= '{link: rdata.link, size: carve_s};
              w2_addr  <= MEM_AW'(carve_h - LINK_W'(1));
              w2_data  <= '{link: carve_h, size: SIZE_W'(nu)};
              user_res <= ADDR_W'(carve_h);
              free_count <= fc_carve;
              if (fc_carve < min_free_count) begin
                min_free_count <= fc_carve;
              end
            end
          end else begin
            pa      <= ca;
            pa_size <= rdata.size;
            ca      <= rdata.link;
            steps   <= steps + STEP_W'(1);
            state   <= S_A_TEST;
          end
        end
        S_R_RD: state <= S_R_CHK;
        S_R_CHK: begin
          if (rdata.link != blk) begin
            done      <= 1'b1;
            ok        <= 1'b0;
            user_addr <= '0;
            state     <= S_IDLE;
          end else begin
            c_size  <= rdata.size;
            pa      <= '0;
            pa_size <= SIZE_W'(1);
            ca      <= sentinel_link;
            steps   <= '0;
            state   <= S_R_TEST;
          end
        end
        S_R_TEST: begin
          if (steps == STEP_W'(WALK_LIMIT)) begin
            done      <= 1'b1;
            ok        <= 1'b0;
            user_addr <= '0;
            state     <= S_IDLE;
          end else if (found) begin
            state <= S_R_MRG;
          end else begin
            steps <= steps + STEP_W'(1);
            pa    <= ca;
            if (ca == '0) begin
              pa_size <= SIZE_W'(1);
              ca      <= sentinel_link;
            end else begin
              state <= S_R_WCHK;
            end
          end
        end
        S_R_WCHK: begin
          pa_size <= rdata.size;
          ca      <= rdata.link;
          state   <= S_R_TEST;
        end
        S_R_MRG: begin
          free_count <= free_count + CNT_W'(c_size);
          w2_addr    <= MEM_AW'(blk - LINK_W'(1));
          w2_data    <= c_new;
          w1_addr    <= MEM_AW'(pa - LINK_W'(1));
          w1_en      <= (pa != '0);
          if (back_merge) begin
            w1_data <= '{link: c_new.link, size: pa_size + c_new.size};
          end else begin
            w1_data <= '{link: blk, size: pa_size};
          end
          if (pa == '0) begin
            sentinel_link <= blk;
          end
          user_res <= '0;
          state    <= S_WR1;
        end
        S_WR1: state <= S_WR2;
        S_WR2: begin
          done      <= 1'b1;
          ok        <= 1'b1;
          user_addr <= user_res;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_min_le_free: assert property (@(posedge clk) disable iff (rst)
    min_free_count <= free_count)
    else $error("low-water mark above free count");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= FREE_INIT)
    else $error("free count above heap capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !ok |-> user_addr == '0)
    else $error("failed transfer carries an address");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_we)
    else $error("header write while idle");

endmodule

`default_nettype wire
